### rtl/rwh_pkg.sv
`timescale 1ns / 1ps

package rwh_pkg;

	// Window store geometry
	localparam int MaxWindow = 64;
	localparam int AddrW     = $clog2(MaxWindow);
	localparam int LenW      = 7;

	// Hash arithmetic widths
	localparam int WordW = 55;
	localparam int DivW  = 64;
	localparam int CntW  = $clog2(DivW + 1);

	// Register reset values
	localparam logic [LenW-1:0]  LenReset = LenW'(10);
	localparam logic [WordW-1:0] ModReset = WordW'(64'd1999999973);
	localparam logic [WordW-1:0] PowReset = '0;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_LEN = 2'd0,
		CFG_MOD = 2'd1,
		CFG_POW = 2'd2
	} cfg_idx_t;

	// Request operation codes
	typedef enum logic {
		OP_FEED  = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	// Commands to the shared reduction unit
	typedef struct packed {
		logic load;   // take a new dividend and restart the remainder
		logic clear;  // zero the remainder
	} rwh_cmd_t;

endpackage

### rtl/rwh_store.sv
`timescale 1ns / 1ps

module rwh_store
	import rwh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             clr,
	input  logic [AddrW-1:0] addr,
	input  logic [7:0]       wdata,
	output logic [7:0]       old_byte
);

	logic [7:0]           mem [MaxWindow];
	logic [7:0]           rd_q;
	logic [MaxWindow-1:0] vld_q;
	logic                 hit_q;

	// Read the leaving byte and write the entering one at the same slot
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	// Track written slots; a clear drops them all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else if (clr) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else if (wr_en) begin
			hit_q       <= vld_q[addr];
			vld_q[addr] <= 1'b1;
		end
	end

	// Never-written slots read as zero
	assign old_byte = hit_q ? rd_q : 8'd0;

endmodule

### rtl/rwh_modred.sv
`timescale 1ns / 1ps

module rwh_modred
	import rwh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rwh_cmd_t         cmd,
	input  logic [DivW-1:0]  load_val,
	input  logic [WordW-1:0] modulus,
	output logic [WordW-1:0] rem,
	output logic             done
);

	logic [WordW-1:0] rem_q;
	logic [DivW-1:0]  div_q;
	logic [CntW-1:0]  cnt_q;
	logic [WordW:0]   trial;
	logic [WordW:0]   diff;
	logic             ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, div_q[DivW-1]};
	assign ge    = trial >= {1'b0, modulus};
	assign diff  = trial - {1'b0, modulus};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.load) begin
			rem_q <= '0;
			cnt_q <= CntW'(DivW);
		end else if (cmd.clear) begin
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[WordW-1:0] : trial[WordW-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Dividend shifts out MSB first
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			div_q <= load_val;
		end else if (cnt_q != '0) begin
			div_q <= {div_q[DivW-2:0], 1'b0};
		end
	end

	assign rem  = rem_q;
	assign done = (cnt_q == '0);

endmodule

### rtl/rolling_window_hash.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid/in_ready    op, byte_in
// output    out_valid/out_ready  hash_out
// config    cfg_we               cfg_index, cfg_data
//
// A feed is sequenced around the shared one-bit-per-cycle reduction: load
// old_byte*exit_power and reduce it bit by bit, load the next dividend and reduce
// it the same way, then register the result into the output.
// A clear goes straight to completion; in_ready rises as a result is registered.
// Reset is asynchronous; the window store needs no clearing pass after it.
// A waiting result does not block a new request; completion holds until it is taken.

module rolling_window_hash
	import rwh_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             op,
	input  logic [7:0]       byte_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WordW-1:0] hash_out,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [WordW-1:0] cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_RED1 = 6'b000100,
		ST_SUM  = 6'b001000,
		ST_RED2 = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t           state_q;
	logic [LenW-1:0]  len_q;
	logic [WordW-1:0] mod_q;
	logic [WordW-1:0] pow_q;
	logic [WordW-1:0] hash_q;
	logic [AddrW-1:0] pos_q;
	logic [7:0]       byte_q;
	logic [WordW-1:0] out_q;
	logic             out_valid_q;

	logic [LenW-1:0]  len_eff;
	logic [WordW-1:0] mod_eff;
	logic [LenW-1:0]  pos_inc;
	logic [AddrW-1:0] pos_next;
	logic             accept;
	logic             feed;
	logic             clr;
	logic             finish;
	logic [7:0]       old_byte;
	logic [DivW-2:0]  prod;
	logic [WordW:0]   sum;
	logic [DivW-1:0]  load_val;
	rwh_cmd_t         cmd;
	logic [WordW-1:0] rem;
	logic             red_done;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LenReset;
			mod_q <= ModReset;
			pow_q <= PowReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEN: len_q <= cfg_data[LenW-1:0];
				CFG_MOD: mod_q <= cfg_data;
				CFG_POW: pow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp length and modulus to their usable ranges
	assign len_eff = (len_q == '0) ? LenW'(1) :
			(len_q > LenW'(MaxWindow)) ? LenW'(MaxWindow) : len_q;
	assign mod_eff = (mod_q < WordW'(2)) ? WordW'(2) : mod_q;

	// Advance the circular position
	assign pos_inc  = {1'b0, pos_q} + LenW'(1);
	assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[AddrW-1:0];

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign feed     = accept && (op == OP_FEED);
	assign clr      = accept && (op == OP_CLEAR);
	assign finish   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	rwh_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (feed),
		.clr      (clr),
		.addr     (pos_next),
		.wdata    (byte_in),
		.old_byte (old_byte)
	);

	// Dividend sources: leaving term, then (hash + p - residue) * 256 + byte
	assign prod = (DivW-1)'(old_byte) * (DivW-1)'(pow_q);
	assign sum  = {1'b0, hash_q} + ({1'b0, mod_eff} - {1'b0, rem});
	assign load_val = (state_q == ST_MUL) ? {1'b0, prod} : {sum, byte_q};

	assign cmd.load  = (state_q == ST_MUL) || (state_q == ST_SUM);
	assign cmd.clear = clr;

	rwh_modred u_modred (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.load_val (load_val),
		.modulus  (mod_eff),
		.rem      (rem),
		.done     (red_done)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= clr ? ST_DONE : ST_MUL;
				ST_MUL:  state_q <= ST_RED1;
				ST_RED1: if (red_done) state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_RED2;
				ST_RED2: if (red_done) state_q <= ST_DONE;
				ST_DONE: if (finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Position and running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hash_q <= '0;
		end else begin
			if (clr) begin
				pos_q  <= '0;
				hash_q <= '0;
			end else if (feed) begin
				pos_q <= pos_next;
			end
			if (finish) hash_q <= rem;
		end
	end

	// Hold the entering byte for the final reduction
	always_ff @(posedge clk) begin
		if (feed) byte_q <= byte_in;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) out_q <= rem;
	end

	assign out_valid = out_valid_q;
	assign hash_out  = out_q;

endmodule
